### rtl/double_ended_stack_assert.svh
// Assertion macros shared by the double-ended stack RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef DOUBLE_ENDED_STACK_ASSERT_SVH
`define DOUBLE_ENDED_STACK_ASSERT_SVH

// Same-cycle implication, checked only out of reset.
`define DES_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("double_ended_stack: check failed");

// Next-cycle implication, checked only out of reset.
`define DES_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("double_ended_stack: check failed");

`endif

### rtl/des_pkg.sv
// Types and codes for the double-ended stack.
// Used by des_ctrl and double_ended_stack; depends on nothing.
package des_pkg;

  localparam int WORD_W = 32;

  localparam logic [2:0] OP_PUSH_TOP = 3'd0;
  localparam logic [2:0] OP_PUSH_BOT = 3'd1;
  localparam logic [2:0] OP_POP_TOP  = 3'd2;
  localparam logic [2:0] OP_POP_BOT  = 3'd3;
  localparam logic [2:0] OP_QUERY    = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  typedef logic signed [WORD_W-1:0] word_t;

  // Result of one operation, apart from the entry count.
  typedef struct packed {
    word_t      popped;
    word_t      top;
    word_t      bot;
    logic       empty;
    logic [1:0] status;
  } des_res_t;

endpackage

### rtl/des_mem.sv
// Word store: one write port and two registered read ports with write forwarding.
// Depends on nothing.
module des_mem #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr_a,
  input  logic [ADDR_W-1:0] rd_addr_b,
  output logic [DATA_W-1:0] rd_data_a,
  output logic [DATA_W-1:0] rd_data_b
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_a_r;
  logic [DATA_W-1:0] rd_b_r;
  logic [DATA_W-1:0] wd_r;
  logic              fwd_a_r;
  logic              fwd_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_r  <= mem[rd_addr_a];
    rd_b_r  <= mem[rd_addr_b];
    wd_r    <= wr_data;
    fwd_a_r <= wr_en && (wr_addr == rd_addr_a);
    fwd_b_r <= wr_en && (wr_addr == rd_addr_b);
  end

  // A read of the address written in the same cycle returns the new word.
  assign rd_data_a = fwd_a_r ? wd_r : rd_a_r;
  assign rd_data_b = fwd_b_r ? wd_r : rd_b_r;

endmodule

### rtl/des_ctrl.sv
// Pointer, count and end-word logic of the double-ended stack; owns the word store.
// Depends on des_pkg and des_mem.
module des_ctrl #(
  parameter int CAPACITY = 64,
  parameter int PTR_W    = 6,
  parameter int CNT_W    = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic [2:0]            opcode,
  input  des_pkg::word_t        push_value,
  output des_pkg::des_res_t     res,
  output logic [CNT_W-1:0]      count
);
  import des_pkg::*;

  localparam logic [PTR_W-1:0] LAST = PTR_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(CAPACITY);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == LAST) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? LAST : p - PTR_W'(1);
  endfunction

  logic [PTR_W-1:0] bp_r, bp_upd, bp_nxt;
  logic [PTR_W-1:0] tp_r, tp_upd, tp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_upd, cnt_nxt;
  word_t            top_r, top_upd;
  word_t            bot_r, bot_upd;
  word_t            top2, bot2;
  word_t            popped;
  logic [1:0]       status;
  logic             wr_en;
  logic [PTR_W-1:0] wr_addr;
  logic [WORD_W-1:0] rd_a, rd_b;
  logic             full, empty;

  assign full  = (cnt_r == FULL);
  assign empty = (cnt_r == '0);
  assign top2  = word_t'(rd_a);
  assign bot2  = word_t'(rd_b);

  always_comb begin
    bp_upd  = bp_r;
    tp_upd  = tp_r;
    cnt_upd = cnt_r;
    top_upd = top_r;
    bot_upd = bot_r;
    popped  = '0;
    status  = ST_OK;
    wr_en   = 1'b0;
    wr_addr = ptr_inc(tp_r);
    unique case (opcode)
      OP_PUSH_TOP: begin
        if (full) begin
          status = ST_OVERFLOW;
        end else begin
          wr_en   = accept;
          wr_addr = ptr_inc(tp_r);
          tp_upd  = ptr_inc(tp_r);
          cnt_upd = cnt_r + CNT_W'(1);
          top_upd = push_value;
          if (empty) begin
            bot_upd = push_value;
          end
        end
      end
      OP_PUSH_BOT: begin
        if (full) begin
          status = ST_OVERFLOW;
        end else begin
          wr_en   = accept;
          wr_addr = ptr_dec(bp_r);
          bp_upd  = ptr_dec(bp_r);
          cnt_upd = cnt_r + CNT_W'(1);
          bot_upd = push_value;
          if (empty) begin
            top_upd = push_value;
          end
        end
      end
      OP_POP_TOP: begin
        if (empty) begin
          status = ST_UNDERFLOW;
        end else begin
          popped  = top_r;
          tp_upd  = ptr_dec(tp_r);
          cnt_upd = cnt_r - CNT_W'(1);
          top_upd = top2;
        end
      end
      OP_POP_BOT: begin
        if (empty) begin
          status = ST_UNDERFLOW;
        end else begin
          popped  = bot_r;
          bp_upd  = ptr_inc(bp_r);
          cnt_upd = cnt_r - CNT_W'(1);
          bot_upd = bot2;
        end
      end
      default: begin
      end
    endcase
  end

  assign bp_nxt  = accept ? bp_upd  : bp_r;
  assign tp_nxt  = accept ? tp_upd  : tp_r;
  assign cnt_nxt = accept ? cnt_upd : cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bp_r  <= '0;
      tp_r  <= LAST;
      cnt_r <= '0;
    end else begin
      bp_r  <= bp_nxt;
      tp_r  <= tp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      top_r <= top_upd;
      bot_r <= bot_upd;
    end
  end

  // The read ports keep the neighbors of both ends ready for the next beat.
  des_mem #(
    .DEPTH  (CAPACITY),
    .ADDR_W (PTR_W),
    .DATA_W (WORD_W)
  ) u_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (push_value),
    .rd_addr_a (ptr_dec(tp_nxt)),
    .rd_addr_b (ptr_inc(bp_nxt)),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  assign res.popped = popped;
  assign res.top    = (cnt_upd == '0) ? '0 : top_upd;
  assign res.bot    = (cnt_upd == '0) ? '0 : bot_upd;
  assign res.empty  = (cnt_upd == '0);
  assign res.status = status;
  assign count      = cnt_upd;

endmodule

### rtl/double_ended_stack.sv
// Double-ended stack of signed 32-bit words held in a circular buffer of CAPACITY entries.
// Each input beat carries one operation (push top, push bottom, pop top, pop bottom or query;
// unused opcodes act as a query) and yields exactly one output beat in the cycle after it is
// accepted, with the popped word, both end words, the entry count, an empty flag and a status.
// A push to a full store is refused with overflow status and a pop from an empty store with
// underflow status; neither changes the contents. End words read 0 when the store is empty.
// The block takes one beat per cycle for as long as the output side keeps up: the words at
// both ends are held in registers, and the two read ports of the store fetch the words next
// to each end every cycle, so any operation finds all the words it needs without waiting.
// The store needs no clearing after reset; only entries that hold counted words are read.
// Depends on des_pkg, des_ctrl, des_mem and double_ended_stack_assert.svh.
`include "double_ended_stack_assert.svh"

module double_ended_stack #(
  parameter int CAPACITY = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [2:0]                       in_opcode,
  input  des_pkg::word_t                   in_push_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output des_pkg::word_t                   out_popped_value,
  output des_pkg::word_t                   out_top_word,
  output des_pkg::word_t                   out_bottom_value,
  output logic [$clog2(CAPACITY + 1)-1:0]  out_entry_total,
  output logic                             out_is_empty,
  output logic [1:0]                       out_status
);
  import des_pkg::*;

  // Slot index and entry count widths follow from the capacity.
  localparam int PTR_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic              accept;
  des_res_t          res;
  logic [CNT_W-1:0]  count;
  logic              out_valid_r, out_valid_nxt;
  des_res_t          res_r;
  logic [CNT_W-1:0]  count_r;
  logic              rep_overflow;
  logic              rep_underflow;

  // A new beat is taken whenever the result register is free or is being emptied now.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  des_ctrl #(
    .CAPACITY (CAPACITY),
    .PTR_W    (PTR_W),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .opcode     (in_opcode),
    .push_value (in_push_value),
    .res        (res),
    .count      (count)
  );

  assign out_valid_nxt = accept || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // The result register loads only with an accepted beat, so a stalled result holds.
  always_ff @(posedge clk) begin
    if (accept) begin
      res_r   <= res;
      count_r <= count;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_popped_value = res_r.popped;
  assign out_top_word     = res_r.top;
  assign out_bottom_value = res_r.bot;
  assign out_entry_total  = count_r;
  assign out_is_empty     = res_r.empty;
  assign out_status       = res_r.status;

  // A reported overflow or underflow on the output side.
  assign rep_overflow  = out_valid_r && (res_r.status == ST_OVERFLOW);
  assign rep_underflow = out_valid_r && (res_r.status == ST_UNDERFLOW);

  // Every accepted beat produces a result in the following cycle.
  `DES_ASSERT_NXT(a_accept_gives_result, clk, rst_n, accept, out_valid_r)
  // The empty flag agrees with the count it is reported with.
  `DES_ASSERT_IMP(a_empty_matches_count, clk, rst_n, out_valid_r, res_r.empty == (count_r == '0))
  // An overflow is only reported against a full store.
  `DES_ASSERT_IMP(a_overflow_when_full, clk, rst_n, rep_overflow, count_r == CNT_W'(CAPACITY))
  // An underflow leaves the store empty and removes no word.
  `DES_ASSERT_IMP(a_underflow_empty, clk, rst_n, rep_underflow, res_r.empty && (res_r.popped == '0))

endmodule

### verif/tb.sv
// Self-checking testbench for double_ended_stack: random and directed deque operations,
// checked beat by beat against a cycle-free prediction of the circular-buffer store.
// Depends on des_pkg and the double_ended_stack RTL; reads no files.
`timescale 1ns / 1ps

module tb;
  import des_pkg::*;

  // Store size of the block under test; the prediction below is written for 64 slots.
  localparam int DEPTH          = 64;
  localparam int LONG_HOLD      = 300;   // output hold-off used to back the block up
  localparam int END_SLACK      = 10;    // quiet cycles after the last expected beat
  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no beat on either channel

  // Opcodes 5 to 7 have no meaning of their own and must behave as a query.
  localparam logic [2:0] OP_SPARE_A = 3'd5;
  localparam logic [2:0] OP_SPARE_B = 3'd6;
  localparam logic [2:0] OP_SPARE_C = 3'd7;

  // One command beat as the sender offers it.
  typedef struct packed {
    logic [2:0] opcode;
    word_t      value;
  } stack_cmd_t;

  // Everything that one result beat reports.
  typedef struct packed {
    word_t      popped;
    word_t      top;
    word_t      bot;
    logic [6:0] total;
    logic       empty;
    logic [1:0] status;
  } stack_view_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] in_opcode = OP_QUERY;
  word_t      in_push_value = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  word_t      out_popped_value;
  word_t      out_top_word;
  word_t      out_bottom_value;
  logic [6:0] out_entry_total;
  logic       out_is_empty;
  logic [1:0] out_status;

  // Command beats waiting to be offered, and result beats predicted but not yet seen.
  stack_cmd_t  op_backlog[$];
  stack_view_t predicted_views[$];
  stack_cmd_t  next_cmd;
  logic        in_taken = 1'b0;

  // Shadow copy of the store: words, bottom slot and number of words held.
  word_t      shadow_words [0:DEPTH-1];
  logic [5:0] shadow_base;
  logic [6:0] shadow_depth;

  // Idling mix, in percent of cycles, set by the sequencer and read by the two drivers.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // The sequencer asks for a long output hold by bumping hold_orders; the receiver
  // counts the hold out itself and marks it served.
  int hold_orders = 0;
  int hold_served = 0;
  int hold_left = 0;

  int fail_count = 0;
  int checked_beats = 0;
  int sent_beats = 0;
  int overflow_hits = 0;
  int underflow_hits = 0;
  int full_hits = 0;
  int quiet_cycles = 0;

  double_ended_stack #(.CAPACITY(DEPTH)) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_push_value    (in_push_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_popped_value (out_popped_value),
    .out_top_word     (out_top_word),
    .out_bottom_value (out_bottom_value),
    .out_entry_total  (out_entry_total),
    .out_is_empty     (out_is_empty),
    .out_status       (out_status)
  );

  always #5 clk = ~clk;

  // Applies one command to the shadow store and returns the beat the block must report.
  // Slot arithmetic is done in 6 bits so that both ends wrap around the buffer.
  task automatic apply_stack_op(input logic [2:0] op, input word_t value,
                                output stack_view_t view);
    logic [5:0] slot;
    view = '0;
    view.status = ST_OK;
    case (op)
      OP_PUSH_TOP: begin
        if (shadow_depth == DEPTH) begin
          view.status = ST_OVERFLOW;
        end else begin
          slot = shadow_base + shadow_depth[5:0];
          shadow_words[slot] = value;
          shadow_depth = shadow_depth + 7'd1;
        end
      end
      OP_PUSH_BOT: begin
        if (shadow_depth == DEPTH) begin
          view.status = ST_OVERFLOW;
        end else begin
          shadow_base = shadow_base - 6'd1;
          shadow_words[shadow_base] = value;
          shadow_depth = shadow_depth + 7'd1;
        end
      end
      OP_POP_TOP: begin
        if (shadow_depth == 0) begin
          view.status = ST_UNDERFLOW;
        end else begin
          slot = shadow_base + shadow_depth[5:0] - 6'd1;
          view.popped = shadow_words[slot];
          shadow_depth = shadow_depth - 7'd1;
        end
      end
      OP_POP_BOT: begin
        if (shadow_depth == 0) begin
          view.status = ST_UNDERFLOW;
        end else begin
          view.popped = shadow_words[shadow_base];
          shadow_base = shadow_base + 6'd1;
          shadow_depth = shadow_depth - 7'd1;
        end
      end
      default: begin
      end
    endcase
    // A full store has depth[5:0] == 0, and base - 1 is then the top slot, as it should be.
    if (shadow_depth != 0) begin
      slot = shadow_base + shadow_depth[5:0] - 6'd1;
      view.top = shadow_words[slot];
      view.bot = shadow_words[shadow_base];
    end
    view.total = shadow_depth;
    view.empty = (shadow_depth == 0);
  endtask

  task automatic compare_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
    end
  endtask

  task automatic add_cmd(input logic [2:0] op, input word_t value);
    stack_cmd_t cmd;
    cmd.opcode = op;
    cmd.value = value;
    op_backlog.push_back(cmd);
  endtask

  // Mostly uniform words, with the two signed extremes and small values mixed in.
  function automatic word_t rand_word();
    case ($urandom_range(9))
      0: rand_word = 32'h8000_0000;
      1: rand_word = 32'h7fff_ffff;
      2: rand_word = word_t'($urandom_range(15)) - 32'sd8;
      default: rand_word = word_t'($urandom);
    endcase
  endfunction

  // Queues a run of random commands; the push and pop shares steer the store toward
  // full or empty, and the rest are queries, including the unused opcodes.
  task automatic queue_run(input int count, input int push_pct, input int pop_pct);
    int roll;
    logic [2:0] op;
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(99);
      if (roll < push_pct) begin
        op = $urandom_range(1) ? OP_PUSH_BOT : OP_PUSH_TOP;
      end else if (roll < push_pct + pop_pct) begin
        op = $urandom_range(1) ? OP_POP_BOT : OP_POP_TOP;
      end else begin
        case ($urandom_range(5))
          0: op = OP_SPARE_A;
          1: op = OP_SPARE_B;
          2: op = OP_SPARE_C;
          default: op = OP_QUERY;
        endcase
      end
      add_cmd(op, rand_word());
    end
  endtask

  // Holds the sequencer until every queued beat went in and every result came back.
  task automatic wait_drained();
    while (op_backlog.size() != 0 || in_valid || predicted_views.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Sender. A new beat may be offered only when the previous one was taken at the last
  // rising edge, or when nothing is on offer; otherwise valid and payload stay put.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (op_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_cmd = op_backlog.pop_front();
        in_valid <= 1'b1;
        in_opcode <= next_cmd.opcode;
        in_push_value <= next_cmd.value;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver. A requested long hold takes priority over the random stall mix.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_orders != hold_served) begin
      out_ready <= 1'b0;
      hold_left <= LONG_HOLD - 1;
      hold_served <= hold_served + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor. Result beats are checked before the prediction of a command taken at the
  // same edge is queued, so a beat can only match commands accepted earlier.
  always @(posedge clk) begin : monitor
    stack_view_t oldest;
    stack_view_t fresh;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        checked_beats++;
        if (predicted_views.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with nothing expected, actual popped %h total %0d",
                   $time, out_popped_value, out_entry_total);
        end else begin
          oldest = predicted_views.pop_front();
          compare_field("popped_value", oldest.popped, out_popped_value);
          compare_field("top_word", oldest.top, out_top_word);
          compare_field("bottom_value", oldest.bot, out_bottom_value);
          compare_field("entry_total", 32'(oldest.total), 32'(out_entry_total));
          compare_field("is_empty", 32'(oldest.empty), 32'(out_is_empty));
          compare_field("status", 32'(oldest.status), 32'(out_status));
        end
      end
      if (in_valid && in_ready) begin
        sent_beats++;
        apply_stack_op(in_opcode, in_push_value, fresh);
        if (fresh.status == ST_OVERFLOW) overflow_hits++;
        if (fresh.status == ST_UNDERFLOW) underflow_hits++;
        if (fresh.total == DEPTH) full_hits++;
        predicted_views.push_back(fresh);
      end
    end
  end

  // Watchdog: a long run of cycles with no beat on either side means the block hung.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("** double_ended_stack: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Sequencer. Its changes to the backlog and the idling mix all happen at rising edges,
  // so the drivers, which act at falling edges, always see settled values.
  initial begin
    shadow_base = '0;
    shadow_depth = '0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    // Directed part: underflow at both ends, the unused opcodes, signed extremes,
    // a single word that is both top and bottom, and a bottom push that wraps slot 0.
    add_cmd(OP_QUERY, 32'sd0);
    add_cmd(OP_POP_TOP, 32'sd0);
    add_cmd(OP_POP_BOT, 32'sd0);
    add_cmd(OP_SPARE_C, 32'hffff_ffff);
    add_cmd(OP_PUSH_TOP, 32'h7fff_ffff);
    add_cmd(OP_PUSH_BOT, 32'h8000_0000);
    add_cmd(OP_QUERY, 32'h1234_5678);
    add_cmd(OP_PUSH_TOP, -32'sd1);
    add_cmd(OP_PUSH_BOT, 32'sd0);
    add_cmd(OP_SPARE_A, 32'h5555_5555);
    add_cmd(OP_POP_TOP, 32'sd0);
    add_cmd(OP_POP_BOT, 32'sd0);
    add_cmd(OP_POP_TOP, 32'sd0);
    add_cmd(OP_POP_BOT, 32'sd0);
    add_cmd(OP_POP_TOP, 32'sd0);
    add_cmd(OP_SPARE_B, 32'haaaa_aaaa);
    add_cmd(OP_PUSH_BOT, 32'sd1);
    add_cmd(OP_POP_TOP, 32'sd0);
    add_cmd(OP_PUSH_TOP, 32'h5555_5555);
    add_cmd(OP_POP_BOT, 32'sd0);
    add_cmd(OP_QUERY, 32'sd0);
    wait_drained();

    // Pressure: a steady stream of pushes at both ends while the output is held off.
    // The block backs up and stalls its input; once released, the pushes fill the
    // store and the last few are refused at both ends.
    for (int k = 0; k < 70; k++) begin
      add_cmd((k % 2) ? OP_PUSH_BOT : OP_PUSH_TOP, rand_word());
    end
    hold_orders = hold_orders + 1;
    wait_drained();

    // Random part, once per idling mix: fill past full, churn near the top, drain past
    // empty, then a short even mix. Each mix ends with the sequencer waiting until drained.
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      queue_run(80, 88, 8);
      queue_run(40, 46, 46);
      queue_run(80, 8, 88);
      queue_run(20, 30, 30);
      wait_drained();
    end

    repeat (END_SLACK) @(posedge clk);
    $display("Ran %0d commands and checked %0d result beats over four idling mixes,",
             sent_beats, checked_beats);
    $display("with %0d refused pushes, %0d refused pops and %0d beats at a full store.",
             overflow_hits, underflow_hits, full_hits);
    if (fail_count == 0) begin
      $display("** double_ended_stack: PASSED **");
    end else begin
      $display("** double_ended_stack: FAILED **");
    end
    $finish;
  end

endmodule
